// ===== src/cbf_pkg.sv =====
// Shared types and constants for the clipped 4bpp box fill engine.
// No dependencies; used by cbf_clip and clipped_box_fill_4bpp.
package cbf_pkg;

  // Field widths fixed by the command format
  localparam int COORD_W = 16;
  localparam int DIM_W   = 11;
  localparam int PIX_W   = 4;
  localparam int COUNT_W = 17;
  localparam int BASE_W  = 22;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 17'h1FFFF;

  // Nibble masks for packed pixels
  localparam logic [7:0] LO_MASK = 8'h0F;
  localparam logic [7:0] HI_MASK = 8'hF0;

  // Command opcodes
  localparam logic [1:0] OP_FILL  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // Configuration register indexes
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_CLIP,
    S_PLAN,
    S_BYTE,
    S_MERGE,
    S_RDATA,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] left;
    logic signed [COORD_W-1:0] right;
    logic signed [COORD_W-1:0] top;
    logic signed [COORD_W-1:0] bottom;
  } box_t;

  typedef struct packed {
    logic               reject;
    logic [COUNT_W-1:0] count;
    logic [DIM_W-1:0]   left_c;
    logic [DIM_W-1:0]   right_c;
    logic [DIM_W-1:0]   top_c;
    logic [DIM_W-1:0]   bottom_c;
    logic [DIM_W-1:0]   pitch;
    logic [BASE_W-1:0]  base;
  } clip_t;

endpackage

// ===== src/cbf_ram.sv =====
// Generic single-port synchronous RAM with registered read.
// No dependencies.
module cbf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write on enable, read every cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== src/cbf_clip.sv =====
// Two-stage check and clip unit for box fill commands.
// Depends on cbf_pkg for box_t, clip_t and field widths.
module cbf_clip #(
  parameter int BUFFER_BYTES = 32768
) (
  input  logic                        clk,
  input  logic [cbf_pkg::DIM_W-1:0]   frame_width,
  input  logic [cbf_pkg::DIM_W-1:0]   frame_height,
  input  cbf_pkg::box_t               box,
  output cbf_pkg::clip_t              clip
);

  logic signed [16:0] l17, r17, t17, b17, w17, h17;
  logic [cbf_pkg::DIM_W-1:0] rb;
  logic bad;
  logic [cbf_pkg::DIM_W-1:0] left_c, right_c, top_c, bottom_c;

  logic                      s1_zero;
  logic                      s1_bad;
  logic [21:0]               s1_rbh;
  logic [cbf_pkg::DIM_W-1:0] s1_left, s1_right, s1_top, s1_bottom, s1_rb;

  logic [11:0] wd, ht;
  logic [23:0] prod;

  // Sign-extend edges and zero-extend frame size to a common compare width
  assign l17 = 17'(box.left);
  assign r17 = 17'(box.right);
  assign t17 = 17'(box.top);
  assign b17 = 17'(box.bottom);
  assign w17 = signed'({6'b0, frame_width});
  assign h17 = signed'({6'b0, frame_height});
  assign rb  = 11'((12'(frame_width) + 12'd1) >> 1);

  // Inverted box or box wholly off the frame
  assign bad = (l17 > r17) || (t17 > b17) || (r17 < 0) || (b17 < 0) ||
               (l17 >= w17) || (t17 >= h17);

  // Clamp edges to the frame
  assign left_c   = (l17 < 0) ? '0 : box.left[cbf_pkg::DIM_W-1:0];
  assign top_c    = (t17 < 0) ? '0 : box.top[cbf_pkg::DIM_W-1:0];
  assign right_c  = (r17 >= w17) ? frame_width - 11'd1 : box.right[cbf_pkg::DIM_W-1:0];
  assign bottom_c = (b17 >= h17) ? frame_height - 11'd1 : box.bottom[cbf_pkg::DIM_W-1:0];

  // Stage 1: checks, clipped edges, buffer footprint
  always_ff @(posedge clk) begin
    s1_zero   <= (frame_width == '0) || (frame_height == '0);
    s1_bad    <= bad;
    s1_rbh    <= 22'(rb) * 22'(frame_height);
    s1_left   <= left_c;
    s1_right  <= right_c;
    s1_top    <= top_c;
    s1_bottom <= bottom_c;
    s1_rb     <= rb;
  end

  assign wd   = 12'(s1_right) - 12'(s1_left) + 12'd1;
  assign ht   = 12'(s1_bottom) - 12'(s1_top) + 12'd1;
  assign prod = 24'(wd) * 24'(ht);

  // Stage 2: verdict, saturated count, first row base address
  always_ff @(posedge clk) begin
    clip.reject    <= s1_zero || s1_bad || (32'(s1_rbh) > 32'(BUFFER_BYTES));
    clip.count     <= (prod > 24'(cbf_pkg::COUNT_MAX)) ? cbf_pkg::COUNT_MAX
                                                       : prod[cbf_pkg::COUNT_W-1:0];
    clip.left_c    <= s1_left;
    clip.right_c   <= s1_right;
    clip.top_c     <= s1_top;
    clip.bottom_c  <= s1_bottom;
    clip.pitch     <= s1_rb;
    clip.base      <= 22'(s1_top) * 22'(s1_rb);
  end

endmodule

// ===== src/clipped_box_fill_4bpp.sv =====
// Top level of the clipped 4bpp box fill engine: command FSM and buffer walker.
// Depends on cbf_pkg, cbf_clip and cbf_ram.
//
//  channel | signals                                         | transfer
//  --------+-------------------------------------------------+-------------------------
//  cmd     | cmd_valid/cmd_ready, opcode, box_*, fill_color, | valid && ready at clk
//          | byte_address, byte_value                        |
//  res     | res_valid/res_ready, filled_count, rejected,    | valid && ready at clk
//          | read_data                                       |
//  cfg     | cfg_we, cfg_index, cfg_data                     | cfg_we at clk
//
// Write, read and other opcodes go from S_DECODE to S_FINISH, a read through S_RDATA;
// a fill goes through S_CLIP and S_PLAN, then visits S_BYTE for each byte of each
// clipped row (none if rejected) and S_MERGE for each half-covered edge byte, which
// needs a read-modify-write on the single RAM port.
// Reset (sync, active high) clears control and loads 320x200; buffer is not cleared.
// A result waits in the output register; the next command is taken meanwhile.
module clipped_box_fill_4bpp #(
  parameter int BUFFER_BYTES = 32768
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic                                cfg_index,
  input  logic [cbf_pkg::DIM_W-1:0]           cfg_data,
  input  logic                                cmd_valid,
  output logic                                cmd_ready,
  input  logic [1:0]                          opcode,
  input  logic signed [cbf_pkg::COORD_W-1:0]  box_left,
  input  logic signed [cbf_pkg::COORD_W-1:0]  box_right,
  input  logic signed [cbf_pkg::COORD_W-1:0]  box_top,
  input  logic signed [cbf_pkg::COORD_W-1:0]  box_bottom,
  input  logic [cbf_pkg::PIX_W-1:0]           fill_color,
  input  logic [14:0]                         byte_address,
  input  logic [7:0]                          byte_value,
  output logic                                res_valid,
  input  logic                                res_ready,
  output logic [cbf_pkg::COUNT_W-1:0]         filled_count,
  output logic                                rejected,
  output logic [7:0]                          read_data
);

  localparam int AW = $clog2(BUFFER_BYTES);

  cbf_pkg::state_t state, state_next;

  logic [cbf_pkg::DIM_W-1:0] frame_width, frame_height;

  // Held command
  logic [1:0]                cmd_op;
  cbf_pkg::box_t             cmd_box;
  logic [cbf_pkg::PIX_W-1:0] cmd_color;
  logic [14:0]               cmd_addr;
  logic [7:0]                cmd_value;
  logic [7:0]                rd_hold;

  cbf_pkg::clip_t clip;

  // Walker
  logic [9:0]    xb;
  logic [10:0]   y;
  logic [AW-1:0] row_base;

  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_wdata;
  logic [7:0]    ram_rdata;

  logic          addr_ok;
  logic          first, last, write_hi, write_lo, full, all_done, advance, out_free;
  logic [AW-1:0] walk_addr;
  logic [7:0]    merged;

  cbf_clip #(.BUFFER_BYTES(BUFFER_BYTES)) u_clip (
    .clk          (clk),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .box          (cmd_box),
    .clip         (clip)
  );

  cbf_ram #(.WIDTH(8), .DEPTH(BUFFER_BYTES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign addr_ok   = 32'(cmd_addr) < 32'(BUFFER_BYTES);
  assign cmd_ready = (state == cbf_pkg::S_IDLE);
  assign out_free  = !res_valid || res_ready;

  // Byte position within the clipped row and nibble enables
  assign first     = (xb == clip.left_c[10:1]);
  assign last      = (xb == clip.right_c[10:1]);
  assign write_hi  = !(first && clip.left_c[0]);
  assign write_lo  = !(last && !clip.right_c[0]);
  assign full      = write_hi && write_lo;
  assign all_done  = last && (y == clip.bottom_c);
  assign walk_addr = AW'(cbf_pkg::BASE_W'(row_base) + cbf_pkg::BASE_W'(xb));
  assign merged    = {write_hi ? cmd_color : ram_rdata[7:4],
                      write_lo ? cmd_color : ram_rdata[3:0]};
  assign advance   = ((state == cbf_pkg::S_BYTE) && full) || (state == cbf_pkg::S_MERGE);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      cbf_pkg::S_IDLE: begin
        if (cmd_valid) state_next = cbf_pkg::S_DECODE;
      end
      cbf_pkg::S_DECODE: begin
        if (cmd_op == cbf_pkg::OP_FILL) state_next = cbf_pkg::S_CLIP;
        else if (cmd_op == cbf_pkg::OP_READ && addr_ok) state_next = cbf_pkg::S_RDATA;
        else state_next = cbf_pkg::S_FINISH;
      end
      cbf_pkg::S_CLIP: state_next = cbf_pkg::S_PLAN;
      cbf_pkg::S_PLAN: begin
        state_next = clip.reject ? cbf_pkg::S_FINISH : cbf_pkg::S_BYTE;
      end
      cbf_pkg::S_BYTE: begin
        if (!full) state_next = cbf_pkg::S_MERGE;
        else if (all_done) state_next = cbf_pkg::S_FINISH;
      end
      cbf_pkg::S_MERGE: begin
        state_next = all_done ? cbf_pkg::S_FINISH : cbf_pkg::S_BYTE;
      end
      cbf_pkg::S_RDATA: state_next = cbf_pkg::S_FINISH;
      cbf_pkg::S_FINISH: begin
        if (out_free) state_next = cbf_pkg::S_IDLE;
      end
      default: state_next = cbf_pkg::S_IDLE;
    endcase
  end

  // RAM port control; reads and writes are strictly serialized, so no
  // read can overlap a pending write to the same byte
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = walk_addr;
    ram_wdata = merged;
    case (state)
      cbf_pkg::S_DECODE: begin
        ram_addr  = AW'(cmd_addr);
        ram_wdata = cmd_value;
        ram_we    = (cmd_op == cbf_pkg::OP_WRITE) && addr_ok;
      end
      cbf_pkg::S_BYTE: begin
        ram_we    = full;
        ram_wdata = {cmd_color, cmd_color};
      end
      cbf_pkg::S_MERGE: ram_we = 1'b1;
      default: ram_we = 1'b0;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= cbf_pkg::S_IDLE;
      res_valid    <= 1'b0;
      frame_width  <= 11'd320;
      frame_height <= 11'd200;
    end else begin
      state <= state_next;
      if (cfg_we && cfg_index == cbf_pkg::REG_FRAME_WIDTH) frame_width <= cfg_data;
      if (cfg_we && cfg_index == cbf_pkg::REG_FRAME_HEIGHT) frame_height <= cfg_data;
      if (state == cbf_pkg::S_FINISH && out_free) res_valid <= 1'b1;
      else if (res_ready) res_valid <= 1'b0;
    end
  end

  // Command hold, walker and result registers
  always_ff @(posedge clk) begin
    if (cmd_valid && cmd_ready) begin
      cmd_op         <= opcode;
      cmd_box.left   <= box_left;
      cmd_box.right  <= box_right;
      cmd_box.top    <= box_top;
      cmd_box.bottom <= box_bottom;
      cmd_color      <= fill_color;
      cmd_addr       <= byte_address;
      cmd_value      <= byte_value;
    end
    if (state == cbf_pkg::S_DECODE) rd_hold <= '0;
    if (state == cbf_pkg::S_RDATA) rd_hold <= ram_rdata;

    // Start at the top-left byte of the clipped box
    if (state == cbf_pkg::S_PLAN) begin
      xb       <= clip.left_c[10:1];
      y        <= clip.top_c;
      row_base <= AW'(clip.base);
    end else if (advance && !all_done) begin
      if (last) begin
        xb       <= clip.left_c[10:1];
        y        <= y + 11'd1;
        row_base <= AW'(cbf_pkg::BASE_W'(row_base) + cbf_pkg::BASE_W'(clip.pitch));
      end else begin
        xb <= xb + 10'd1;
      end
    end

    if (state == cbf_pkg::S_FINISH && out_free) begin
      filled_count <= (cmd_op == cbf_pkg::OP_FILL && !clip.reject) ? clip.count : '0;
      rejected     <= (cmd_op == cbf_pkg::OP_FILL) && clip.reject;
      read_data    <= rd_hold;
    end
  end

  // A merge write always follows the read of the same byte
  a_merge_after_read: assert property (@(posedge clk) disable iff (rst)
    state == cbf_pkg::S_MERGE |-> $past(state == cbf_pkg::S_BYTE) && $stable(walk_addr))
    else $error("merge without preceding read of the same byte");

  // Walker stays inside the clipped columns and does not pass the bottom row
  a_walk_in_box: assert property (@(posedge clk) disable iff (rst)
    state == cbf_pkg::S_BYTE |-> (y <= clip.bottom_c) && (xb <= clip.right_c[10:1])
                                 && (xb >= clip.left_c[10:1]))
    else $error("walker left the clipped box");

  // A rejected fill reports no pixels and no read data
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && rejected |-> filled_count == '0 && read_data == '0)
    else $error("rejected result carries data");

  // Finishing loads the result and frees the command side
  a_finish_load: assert property (@(posedge clk) disable iff (rst)
    state == cbf_pkg::S_FINISH && out_free |=> res_valid && cmd_ready)
    else $error("result not loaded on finish");

endmodule
